### hdl/assert_macros.svh
// Assertion macros used by the pulse detector controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pdb_pkg.sv
// Shared widths, constants and controller/datapath interface types
package pdb_pkg;

  localparam int SAMPLE_W          = 18;
  localparam int STAMP_W           = 32;
  localparam int RATE_W            = 26;
  localparam int CFG_W             = 18;
  localparam int CFG_IDX_W         = 1;
  localparam int DIV_W             = 32;
  localparam int HISTORY_DEPTH_DEF = 10;

  localparam logic [DIV_W-1:0]     RATE_NUMERATOR = 32'd60000000;
  localparam logic [CFG_W-1:0]     UPPER_RESET    = 18'd2000;
  localparam logic [CFG_W-1:0]     LOWER_RESET    = 18'd100;

  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'd1;

  typedef enum logic {
    DIV_RATE,
    DIV_AVG
  } div_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     step;       // input word accepted: update detector
    logic     div_start;
    div_sel_t div_sel;
    logic     rate_wr;    // capture divider quotient as beat rate
    logic     ring_wr;    // push rate into history, update sum
    logic     avg_wr;     // capture divider quotient as average
    logic     out_load;
    logic     out_beat;
  } pdb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic beat;           // current input word completes a beat
    logic interval_zero;
    logic div_done;
  } pdb_sts_t;

endpackage

### hdl/pdb_div.sv
// Restoring unsigned divider, one quotient bit per cycle
module pdb_div
  import pdb_pkg::*;
#(
  parameter int W = DIV_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic         done
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dsr_r;
  logic [W:0]       rem_sh;
  logic [W:0]       trial;

  assign rem_sh = {rem_r, quo_r[W-1]};
  assign trial  = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W - 1);
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        // keep the trial difference when it does not go negative
        if (!trial[W]) begin
          rem_r <= trial[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

### hdl/pdb_datapath.sv
// Datapath: thresholds, peak tracking, history ring, divider and result register
module pdb_datapath
  import pdb_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic [STAMP_W-1:0]   in_timestamp_us,
  input  pdb_cmd_t             cmd,
  output pdb_sts_t             sts,
  output logic                 out_beat,
  output logic [RATE_W-1:0]    out_bpm_average,
  output logic [SAMPLE_W-1:0]  out_peak_level
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = RATE_W + CNT_W;

  typedef enum logic [1:0] {
    DET_IDLE,
    DET_UP,
    DET_DOWN
  } det_t;

  logic [CFG_W-1:0]    upper_r;
  logic [CFG_W-1:0]    lower_r;

  det_t                det_r, det_nxt;
  logic [SAMPLE_W-1:0] prev_sample_r, prev_sample_nxt;
  logic [STAMP_W-1:0]  peak_time_r, peak_time_nxt;
  logic [STAMP_W-1:0]  prev_peak_r, prev_peak_nxt;
  logic [SAMPLE_W-1:0] peak_level_r, peak_level_nxt;

  logic [RATE_W-1:0]   ring_r [HISTORY_DEPTH];
  logic [IDX_W-1:0]    idx_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [RATE_W-1:0]   rate_r;
  logic [RATE_W-1:0]   avg_r;

  logic                over;
  logic                beat;
  logic [STAMP_W-1:0]  interval;

  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;
  logic [DIV_W-1:0]    div_quo;
  logic                div_done;

  logic                out_beat_r;
  logic [RATE_W-1:0]   out_bpm_r;
  logic [SAMPLE_W-1:0] out_peak_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RESET;
      lower_r <= LOWER_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_UPPER) begin
        upper_r <= cfg_data;
      end
      if (cfg_index == REG_LOWER) begin
        lower_r <= cfg_data;
      end
    end
  end

  assign interval = peak_time_r - prev_peak_r;
  assign over     = in_sample_value > upper_r;

  // Detector next state for the word on the input
  always_comb begin
    det_nxt         = det_r;
    prev_sample_nxt = in_sample_value;
    peak_time_nxt   = peak_time_r;
    prev_peak_nxt   = prev_peak_r;
    peak_level_nxt  = peak_level_r;
    beat            = 1'b0;
    if (over) begin
      det_nxt         = DET_IDLE;
      prev_sample_nxt = '0;
      peak_time_nxt   = '0;
      prev_peak_nxt   = '0;
      peak_level_nxt  = '0;
    end else begin
      case (det_r)
        DET_IDLE: begin
          if (in_sample_value >= lower_r) begin
            det_nxt = DET_UP;
          end
        end
        DET_UP: begin
          if (in_sample_value > prev_sample_r) begin
            peak_time_nxt  = in_timestamp_us;
            peak_level_nxt = in_sample_value;
          end else begin
            // trace no longer rising: beat, previous sample held
            beat            = 1'b1;
            det_nxt         = DET_DOWN;
            prev_peak_nxt   = peak_time_r;
            prev_sample_nxt = prev_sample_r;
          end
        end
        DET_DOWN: begin
          if (in_sample_value < lower_r) begin
            det_nxt = DET_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r         <= DET_IDLE;
      prev_sample_r <= '0;
      peak_time_r   <= '0;
      prev_peak_r   <= '0;
      peak_level_r  <= '0;
    end else if (cmd.step) begin
      det_r         <= det_nxt;
      prev_sample_r <= prev_sample_nxt;
      peak_time_r   <= peak_time_nxt;
      prev_peak_r   <= prev_peak_nxt;
      peak_level_r  <= peak_level_nxt;
    end
  end

  // Rate history ring with running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      idx_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
      avg_r <= '0;
    end else begin
      if (cmd.ring_wr) begin
        ring_r[idx_r] <= rate_r;
        sum_r <= sum_r - SUM_W'(ring_r[idx_r]) + SUM_W'(rate_r);
        if (idx_r == IDX_W'(HISTORY_DEPTH - 1)) begin
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
        if (cnt_r < CNT_W'(HISTORY_DEPTH)) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.avg_wr) begin
        avg_r <= div_quo[RATE_W-1:0];
      end
    end
  end

  // Zero interval stores a zero rate; otherwise the quotient replaces it
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rate_r <= '0;
    end else if (cmd.rate_wr) begin
      rate_r <= div_quo[RATE_W-1:0];
    end
  end

  assign div_dividend = (cmd.div_sel == DIV_RATE) ? RATE_NUMERATOR : DIV_W'(sum_r);
  assign div_divisor  = (cmd.div_sel == DIV_RATE) ? DIV_W'(interval) : DIV_W'(cnt_r);

  pdb_div #(
    .W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Result word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_beat_r <= cmd.out_beat;
      out_bpm_r  <= avg_r;
      out_peak_r <= cmd.step ? peak_level_nxt : peak_level_r;
    end
  end

  assign sts.beat          = beat;
  assign sts.interval_zero = (interval == '0);
  assign sts.div_done      = div_done;

  assign out_beat        = out_beat_r;
  assign out_bpm_average = out_bpm_r;
  assign out_peak_level  = out_peak_r;

endmodule

### hdl/pdb_ctrl.sv
// Controller: handshakes and sequencing of the beat-rate computation
`include "assert_macros.svh"

module pdb_ctrl
  import pdb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output pdb_cmd_t cmd,
  input  pdb_sts_t sts
);

  typedef enum logic [2:0] {
    S_WAIT,
    S_RDIV,
    S_RING,
    S_ASTART,
    S_ADIV,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_WAIT) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DIV_RATE;
    case (state_r)
      S_WAIT: begin
        if (accept) begin
          cmd.step = 1'b1;
          if (sts.beat) begin
            cmd.div_start = !sts.interval_zero;
            state_nxt     = sts.interval_zero ? S_RING : S_RDIV;
          end else begin
            cmd.out_load = 1'b1;
          end
        end
      end
      S_RDIV: begin
        if (sts.div_done) begin
          cmd.rate_wr = 1'b1;
          state_nxt   = S_RING;
        end
      end
      S_RING: begin
        cmd.ring_wr = 1'b1;
        state_nxt   = S_ASTART;
      end
      S_ASTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
        state_nxt     = S_ADIV;
      end
      S_ADIV: begin
        cmd.div_sel = DIV_AVG;
        if (sts.div_done) begin
          cmd.avg_wr = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        // wait for the result register to drain
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_beat = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_IMPLY(a_busy_stall, clk, rst_n, state_r != S_WAIT, in_stall, "input taken while busy")
  `ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.out_load, out_free, "result word overwritten")
  `ASSERT_IMPLY(a_done_in_div, clk, rst_n, sts.div_done, (state_r == S_RDIV) || (state_r == S_ADIV), "divider done outside a divide state")
  `ASSERT_NEXT(a_beat_seq, clk, rst_n, cmd.step && sts.beat, (state_r == S_RDIV) || (state_r == S_RING), "beat did not start rate update")

endmodule

### hdl/pulse_detect_bpm.sv
// Pulse beat detector with averaged beats per minute: top level
// Takes one filtered pulse sample with its microsecond timestamp per input word
// and returns one result word per sample: a beat flag, the averaged rate over
// the last HISTORY_DEPTH beats, and the latest peak level. A sample that does
// not complete a beat is loaded into the result register when accepted, and
// the next sample may follow at once unless the output stalls. A beat sample
// stalls the input while the 32-step bit-serial divider runs for 60000000 over
// the peak interval (if nonzero), then for the history sum over the beat
// count. The user must write cfg port thresholds only while idle; not enforced.
module pulse_detect_bpm
  import pdb_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic [STAMP_W-1:0]   in_timestamp_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_beat,
  output logic [RATE_W-1:0]    out_bpm_average,
  output logic [SAMPLE_W-1:0]  out_peak_level
);

  pdb_cmd_t cmd;
  pdb_sts_t sts;

  pdb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  pdb_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample_value (in_sample_value),
    .in_timestamp_us (in_timestamp_us),
    .cmd             (cmd),
    .sts             (sts),
    .out_beat        (out_beat),
    .out_bpm_average (out_bpm_average),
    .out_peak_level  (out_peak_level)
  );

endmodule
